// File: rtl/core/smsk_pkg.sv
`timescale 1ns / 1ps

package smsk_pkg;

   localparam int MAX_SAMPLES = 65535;
   localparam int SAMPLE_BITS = 16;

   // Width of the shared multiplier operands and the digit it retires per cycle.
   localparam int MUL_W      = 64;
   localparam int MUL_DIGIT  = 16;
   localparam int MUL_STEPS  = MUL_W / MUL_DIGIT;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [24:0] skewness;
      logic               result_valid;
      logic [15:0]        sample_count;
      logic               overflow;
   } rsp_type;

endpackage

// File: rtl/core/streaming_moment_skewness.sv
`timescale 1ns / 1ps

// Streaming sample skewness with Welford moment updates.
// The request channel (req_valid, req_ready, req_payload) carries an opcode
// and a signed sample. Add updates count, mean and the second and third
// central moments; clear zeroes all state; query and the unused code only
// report. Every request transfer yields exactly one response transfer on
// rsp_valid, rsp_ready, rsp_payload with skewness in signed Q8.16, a valid
// flag, the sample count and a sticky overflow flag.
// One request is in flight at a time; req_ready is high only while idle.
// An add runs the moment update and then the skewness; a query with nonzero
// dispersion or an add dropped on a full set runs only the skewness; a clear or
// a query with zero dispersion goes straight to the response. The work is a
// 49-step restoring divide by the count, two 32-step square roots and a 25-step
// quotient, all on one shared compare-subtract unit, plus up to twelve scaling
// steps and up to seven products on a shared 64x16 multiplier.
// The response sits in an output register, so the next request is accepted
// while it waits; a stalled receiver only holds the following item at its end.
// Synchronous reset clears all moments, the count and the overflow flag.
module streaming_moment_skewness (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smsk_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smsk_pkg::rsp_type rsp_payload
);
   import smsk_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE  = 12'h001,
      S_DIV   = 12'h002,
      S_MEAN  = 12'h004,
      S_MUL   = 12'h008,
      S_SAT3  = 12'h010,
      S_DIFF  = 12'h020,
      S_UPD   = 12'h040,
      S_SKEW0 = 12'h080,
      S_SCALE = 12'h100,
      S_SQRT  = 12'h200,
      S_SDIV  = 12'h400,
      S_DONE  = 12'h800
   } state_type;

   // Which product the shared multiplier is working on.
   typedef enum logic [2:0] {
      MS_C1  = 3'd0,
      MS_T1  = 3'd1,
      MS_C2  = 3'd2,
      MS_P   = 3'd3,
      MS_Q   = 3'd4,
      MS_DEN = 3'd5,
      MS_NUM = 3'd6
   } msel_type;

   localparam logic [63:0] Q3_LIMIT = 64'h5555_5555_5555_5555;
   localparam logic [24:0] LIM_POS  = 25'h0FF_FFFF;
   localparam logic [24:0] LIM_NEG  = 25'h100_0000;
   localparam logic [63:0] BIT_TOP  = 64'h4000_0000_0000_0000;

   state_type   state_ff, state_in;
   msel_type    msel_ff, msel_in;
   logic        mgo_ff, mgo_in;
   logic [15:0] count_ff, count_in;
   logic [47:0] mean_ff, mean_in;
   logic [63:0] m2_ff, m2_in;
   logic [63:0] m3_ff, m3_in;
   logic        ovf_ff, ovf_in;
   logic        rspv_ff, rspv_in;
   rsp_type     rsp_ff, rsp_in;

   logic [48:0] a_ff, a_in;
   logic        neg_ff, neg_in;
   logic [15:0] n_ff, n_in;
   logic [48:0] dn_ff, dn_in;
   logic [72:0] rem_ff, rem_in;
   logic [63:0] c_ff, c_in;
   logic [63:0] t1_ff, t1_in;
   logic [63:0] p_ff, p_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] m2s_ff, m2s_in;
   logic [63:0] mag3_ff, mag3_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [31:0] sq_ff, sq_in;
   logic [71:0] den_ff, den_in;
   logic [24:0] qt_ff, qt_in;
   logic        sgn_ff, sgn_in;
   logic        ssat_ff, ssat_in;
   logic        sqph_ff, sqph_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic               req_xfer;
   logic signed [15:0] x_s;
   logic signed [48:0] d_s;
   logic [72:0]        cs_a, cs_b;
   logic [73:0]        cs_diff;
   logic               cs_ge;
   logic [63:0]        mul_a, mul_b;
   logic               mul_done;
   logic [127:0]       mul_prod;
   logic               sat48, sat33;
   logic [63:0]        val48, val33;
   logic [63:0]        res_bit, res_nx;
   logic [64:0]        q3_sum, m2_sum;
   logic signed [65:0] e_s, m3_sum;
   logic [24:0]        lim, mag_fin;
   logic               qt_over;

   smsk_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mgo_ff),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign req_xfer    = req_valid && req_ready;
   assign rsp_valid   = rspv_ff;
   assign rsp_payload = rsp_ff;

   // Difference of the sample (as Q.32) and the running mean.
   assign x_s = 16'($signed(req_payload.sample[SAMPLE_BITS-1:0]));
   assign d_s = $signed({x_s[15], x_s, 32'd0}) - $signed({mean_ff[47], mean_ff});

   assign cs_diff = {1'b0, cs_a} - {1'b0, cs_b};
   assign cs_ge   = !cs_diff[73];

   assign sat48 = |mul_prod[127:112];
   assign val48 = sat48 ? '1 : mul_prod[111:48];
   assign sat33 = |mul_prod[127:97];
   assign val33 = sat33 ? '1 : mul_prod[96:33];

   assign res_bit = res_ff + bit_ff;
   assign res_nx  = cs_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   assign q3_sum = {1'b0, q_ff} + {q_ff, 1'b0};
   assign m2_sum = {1'b0, m2_ff} + {1'b0, t1_ff};
   assign e_s    = neg_ff ? -$signed({2'b00, p_ff}) : $signed({2'b00, p_ff});
   assign m3_sum = $signed({{2{m3_ff[63]}}, m3_ff}) + e_s;

   assign lim     = sgn_ff ? LIM_NEG : LIM_POS;
   assign qt_over = !ssat_ff && (qt_ff > lim);
   assign mag_fin = (ssat_ff || qt_over) ? lim : qt_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (msel_ff)
         MS_C1: begin
            mul_a = {15'd0, dn_ff};
            mul_b = {48'd0, n_ff - 16'd1};
         end
         MS_T1: begin
            mul_a = {15'd0, a_ff};
            mul_b = c_ff;
         end
         MS_C2: begin
            mul_a = {15'd0, dn_ff};
            mul_b = (n_ff >= 16'd2) ? {48'd0, n_ff - 16'd2} : 64'd0;
         end
         MS_P: begin
            mul_a = t1_ff;
            mul_b = c_ff;
         end
         MS_Q: begin
            mul_a = m2_ff;
            mul_b = {15'd0, dn_ff};
         end
         MS_DEN: begin
            mul_a = m2s_ff;
            mul_b = {32'd0, sq_ff};
         end
         MS_NUM: begin
            mul_a = mag3_ff;
            mul_b = res_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Operand selection for the shared compare-subtract unit.
   always_comb begin
      cs_a = '0;
      cs_b = '0;
      case (state_ff)
         S_DIV: begin
            cs_a = {56'd0, rem_ff[15:0], dn_ff[48]};
            cs_b = {57'd0, n_ff};
         end
         S_SQRT: begin
            cs_a = rem_ff;
            cs_b = {9'd0, res_bit};
         end
         S_MUL: begin
            cs_a = mul_prod[72:0];
            cs_b = {1'b0, den_ff};
         end
         S_SDIV: begin
            cs_a = {rem_ff[71:0], 1'b0};
            cs_b = {1'b0, den_ff};
         end
         default: begin
            cs_a = '0;
            cs_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      msel_in  = msel_ff;
      mgo_in   = 1'b0;
      count_in = count_ff;
      mean_in  = mean_ff;
      m2_in    = m2_ff;
      m3_in    = m3_ff;
      ovf_in   = ovf_ff;
      rspv_in  = rspv_ff;
      rsp_in   = rsp_ff;
      a_in     = a_ff;
      neg_in   = neg_ff;
      n_in     = n_ff;
      dn_in    = dn_ff;
      rem_in   = rem_ff;
      c_in     = c_ff;
      t1_in    = t1_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      m2s_in   = m2s_ff;
      mag3_in  = mag3_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      sq_in    = sq_ff;
      den_in   = den_ff;
      qt_in    = qt_ff;
      sgn_in   = sgn_ff;
      ssat_in  = ssat_ff;
      sqph_in  = sqph_ff;
      cnt_in   = cnt_ff;

      if (rspv_ff && rsp_ready) begin
         rspv_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_SKEW0;
               case (req_payload.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                     mean_in  = '0;
                     m2_in    = '0;
                     m3_in    = '0;
                     ovf_in   = 1'b0;
                  end
                  OP_ADD: begin
                     if (32'(count_ff) >= MAX_SAMPLES) begin
                        ovf_in = 1'b1;
                     end else begin
                        neg_in   = d_s[48];
                        a_in     = d_s[48] ? 49'(-d_s) : 49'(d_s);
                        dn_in    = d_s[48] ? 49'(-d_s) : 49'(d_s);
                        n_in     = count_ff + 16'd1;
                        rem_in   = '0;
                        cnt_in   = '0;
                        state_in = S_DIV;
                     end
                  end
                  OP_QUERY: begin
                     state_in = S_SKEW0;
                  end
                  default: begin
                     state_in = S_SKEW0;
                  end
               endcase
            end
         end

         // Restoring division of |d| by the new count, one quotient bit a cycle.
         S_DIV: begin
            if (cs_ge) begin
               rem_in = {56'd0, cs_diff[16:0]};
            end else begin
               rem_in = {56'd0, cs_a[16:0]};
            end
            dn_in  = {dn_ff[47:0], cs_ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd48) begin
               state_in = S_MEAN;
            end
         end

         S_MEAN: begin
            mean_in  = neg_ff ? (mean_ff - dn_ff[47:0]) : (mean_ff + dn_ff[47:0]);
            msel_in  = MS_C1;
            mgo_in   = 1'b1;
            state_in = S_MUL;
         end

         S_MUL: begin
            if (mul_done) begin
               case (msel_ff)
                  MS_C1: begin
                     c_in    = mul_prod[63:0];
                     msel_in = MS_T1;
                     mgo_in  = 1'b1;
                  end
                  MS_T1: begin
                     t1_in   = val48;
                     ovf_in  = ovf_ff | sat48;
                     msel_in = MS_C2;
                     mgo_in  = 1'b1;
                  end
                  MS_C2: begin
                     c_in    = mul_prod[63:0];
                     msel_in = MS_P;
                     mgo_in  = 1'b1;
                  end
                  MS_P: begin
                     p_in    = val33;
                     ovf_in  = ovf_ff | sat33;
                     msel_in = MS_Q;
                     mgo_in  = 1'b1;
                  end
                  MS_Q: begin
                     q_in     = val33;
                     ovf_in   = ovf_ff | sat33;
                     state_in = S_SAT3;
                  end
                  MS_DEN: begin
                     den_in  = mul_prod[71:0];
                     msel_in = MS_NUM;
                     mgo_in  = 1'b1;
                  end
                  MS_NUM: begin
                     // A quotient of 2^25 or more is out of range whatever its sign.
                     if ((|mul_prod[127:73]) || cs_ge) begin
                        ssat_in  = 1'b1;
                        ovf_in   = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        rem_in   = mul_prod[72:0];
                        qt_in    = '0;
                        cnt_in   = '0;
                        state_in = S_SDIV;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SAT3: begin
            if (q_ff > Q3_LIMIT) begin
               q_in   = '1;
               ovf_in = 1'b1;
            end else begin
               q_in = q3_sum[63:0];
            end
            state_in = S_DIFF;
         end

         // The third-moment increment as a sign and a magnitude.
         S_DIFF: begin
            if (p_ff >= q_ff) begin
               p_in   = p_ff - q_ff;
               neg_in = neg_ff;
            end else begin
               p_in   = q_ff - p_ff;
               neg_in = !neg_ff;
            end
            state_in = S_UPD;
         end

         S_UPD: begin
            if (m3_sum[65:63] != {3{m3_sum[65]}}) begin
               m3_in  = m3_sum[65] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
               ovf_in = 1'b1;
            end else begin
               m3_in = m3_sum[63:0];
            end
            if (m2_sum[64]) begin
               m2_in  = '1;
               ovf_in = 1'b1;
            end else begin
               m2_in = m2_sum[63:0];
            end
            count_in = n_ff;
            state_in = S_SKEW0;
         end

         S_SKEW0: begin
            ssat_in = 1'b0;
            qt_in   = '0;
            if (count_ff == 16'd0 || m2_ff == 64'd0) begin
               sgn_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               sgn_in   = m3_ff[63];
               mag3_in  = m3_ff[63] ? (~m3_ff + 64'd1) : m3_ff;
               m2s_in   = m2_ff;
               state_in = S_SCALE;
            end
         end

         // Bring m2 below 2^40 so that m2 << 24 fits the root unit.
         S_SCALE: begin
            if (|m2s_ff[63:40]) begin
               m2s_in  = m2s_ff >> 2;
               mag3_in = mag3_ff >> 3;
            end else begin
               rem_in   = {9'd0, m2s_ff[39:0], 24'd0};
               res_in   = '0;
               bit_in   = BIT_TOP;
               cnt_in   = '0;
               sqph_in  = 1'b0;
               state_in = S_SQRT;
            end
         end

         // Digit-by-digit integer square root, one result bit a cycle.
         S_SQRT: begin
            if (cs_ge) begin
               rem_in = cs_diff[72:0];
            end
            res_in = res_nx;
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               if (!sqph_ff) begin
                  sq_in   = res_nx[31:0];
                  rem_in  = {33'd0, count_ff, 24'd0};
                  res_in  = '0;
                  bit_in  = BIT_TOP;
                  cnt_in  = '0;
                  sqph_in = 1'b1;
               end else begin
                  msel_in  = MS_DEN;
                  mgo_in   = 1'b1;
                  state_in = S_MUL;
               end
            end
         end

         // The 25 quotient bits of the skewness, remainder below the divisor.
         S_SDIV: begin
            if (cs_ge) begin
               rem_in = cs_diff[72:0];
            end else begin
               rem_in = cs_a;
            end
            qt_in  = {qt_ff[23:0], cs_ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd24) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rspv_ff || rsp_ready) begin
               rsp_in.skewness     = sgn_ff ? $signed(-mag_fin) : $signed(mag_fin);
               rsp_in.result_valid = (count_ff != 16'd0);
               rsp_in.sample_count = count_ff;
               rsp_in.overflow     = ovf_ff | qt_over;
               ovf_in              = ovf_ff | qt_over;
               rspv_in             = 1'b1;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         msel_ff  <= MS_C1;
         mgo_ff   <= 1'b0;
         count_ff <= '0;
         mean_ff  <= '0;
         m2_ff    <= '0;
         m3_ff    <= '0;
         ovf_ff   <= 1'b0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         msel_ff  <= msel_in;
         mgo_ff   <= mgo_in;
         count_ff <= count_in;
         mean_ff  <= mean_in;
         m2_ff    <= m2_in;
         m3_ff    <= m3_in;
         ovf_ff   <= ovf_in;
         rspv_ff  <= rspv_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      n_ff    <= n_in;
      dn_ff   <= dn_in;
      rem_ff  <= rem_in;
      c_ff    <= c_in;
      t1_ff   <= t1_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      m2s_ff  <= m2s_in;
      mag3_ff <= mag3_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      sq_ff   <= sq_in;
      den_ff  <= den_in;
      qt_ff   <= qt_in;
      sgn_ff  <= sgn_in;
      ssat_ff <= ssat_in;
      sqph_ff <= sqph_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// File: rtl/core/smsk_mul.sv
`timescale 1ns / 1ps

module smsk_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [smsk_pkg::MUL_W-1:0]     mul_a,
   input  logic [smsk_pkg::MUL_W-1:0]     mul_b,
   output logic                           done,
   output logic [2*smsk_pkg::MUL_W-1:0]   product
);
   import smsk_pkg::*;

   // Right-shifting multiplier: one digit of mul_b is retired per cycle.
   logic [MUL_W-1:0]           a_ff;
   logic [MUL_W-1:0]           h_ff;
   logic [MUL_W-1:0]           l_ff;
   logic [MUL_CNT_W-1:0]       cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [MUL_W+MUL_DIGIT-1:0] part;
   logic [MUL_W+MUL_DIGIT-1:0] sum;

   assign part = a_ff * l_ff[MUL_DIGIT-1:0];
   assign sum  = {{MUL_DIGIT{1'b0}}, h_ff} + part;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         a_ff <= mul_a;
         h_ff <= '0;
         l_ff <= mul_b;
      end else if (busy_ff) begin
         h_ff <= sum[MUL_W+MUL_DIGIT-1:MUL_DIGIT];
         l_ff <= {sum[MUL_DIGIT-1:0], l_ff[MUL_W-1:MUL_DIGIT]};
      end
   end

   assign done    = done_ff;
   assign product = {h_ff, l_ff};

endmodule
